// ===== rtl/spcrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Scratchpad CRC checker package
// Field widths, command, status and phase codes, and the CRC polynomial.
// ----------------------------------------------------------------------------
package spcrc_pkg;

    // Payload field widths
    localparam int CMD_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int TEMP_W   = 16;

    // Default frame length: eight data bytes and one check byte
    localparam int FRAME_BYTES_DEF = 9;

    // Reflected CRC-8, shifted out LSB first
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8c;

    // Input commands
    localparam logic [CMD_W-1:0] CMD_START    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PRESENCE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BYTE     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_RETRY = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FAIL  = 2'd2;

    // Phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_RECV = 2'd2;

endpackage

// ===== rtl/spcrc_if.sv =====
// ----------------------------------------------------------------------------
// Scratchpad CRC checker channels
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface spcrc_in_if;
    logic                          valid;
    logic                          ready;
    logic [spcrc_pkg::CMD_W-1:0]   command;
    logic [spcrc_pkg::BYTE_W-1:0]  attempts;
    logic                          presence;
    logic [spcrc_pkg::BYTE_W-1:0]  data_byte;

    modport source (output valid, command, attempts, presence, data_byte, input ready);
    modport sink   (input valid, command, attempts, presence, data_byte, output ready);
endinterface

interface spcrc_out_if;
    logic                            valid;
    logic                            ready;
    logic [spcrc_pkg::STATUS_W-1:0]  status;
    logic [spcrc_pkg::TEMP_W-1:0]    temperature;
    logic [spcrc_pkg::BYTE_W-1:0]    crc_value;

    modport source (output valid, status, temperature, crc_value, input ready);
    modport sink   (input valid, status, temperature, crc_value, output ready);
endinterface

// ===== rtl/scratchpad_crc_checker.sv =====
// ----------------------------------------------------------------------------
// Scratchpad CRC checker
// Checks a sensor scratchpad read with a retry budget and a CRC-8 check.
// ----------------------------------------------------------------------------
// Usage: the input channel i_in takes one word per command: start (loads the
// attempt budget), presence result, or one received scratchpad byte. The
// output channel o_out returns at most one result word per input word:
// retry, success with the temperature word, or failure.
// Timing: a word is captured in the input register when it is accepted, and
// its result is loaded into the output register when the word advances,
// which waits while a held result still occupies the output register.
// Throughput: one word per cycle while o_out is not held; the unrolled
// combinational CRC-8 byte update lies between the input and state registers.
// Reset: synchronous active-low i_rst_n empties both registers, sets the
// phase to idle and clears the attempt count, byte index and CRC.
// Stall: while o_out is held, one further word may wait in the input
// register; after that i_in.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module scratchpad_crc_checker #(
    parameter int FRAME_BYTES = spcrc_pkg::FRAME_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    spcrc_in_if.sink         i_in,
    spcrc_out_if.source      o_out
);

    localparam int IDX_W = $clog2(FRAME_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

    // Input register
    logic                          r_in_valid;
    logic [spcrc_pkg::CMD_W-1:0]   r_cmd;
    logic [spcrc_pkg::BYTE_W-1:0]  r_budget;
    logic                          r_present;
    logic [spcrc_pkg::BYTE_W-1:0]  r_byte;

    // Checker state
    logic [1:0]                    r_phase, n_phase;
    logic [spcrc_pkg::BYTE_W-1:0]  r_left, n_left;
    logic [IDX_W-1:0]              r_idx, n_idx;
    logic [spcrc_pkg::BYTE_W-1:0]  r_crc, n_crc;
    logic [spcrc_pkg::BYTE_W-1:0]  r_tlo, n_tlo;
    logic [spcrc_pkg::BYTE_W-1:0]  r_thi, n_thi;

    // Output register
    logic                            r_out_valid, n_out_valid;
    logic [spcrc_pkg::STATUS_W-1:0]  r_status, n_status;
    logic [spcrc_pkg::TEMP_W-1:0]    r_temp, n_temp;
    logic [spcrc_pkg::BYTE_W-1:0]    r_crc_out, n_crc_out;

    logic                            adv;
    logic [spcrc_pkg::BYTE_W-1:0]    crc_upd;
    logic [spcrc_pkg::BYTE_W-1:0]    left_dec;

    // Advance the held word when the output register can take its result
    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    spcrc_crc8 u_crc8 (
        .i_crc  (r_crc),
        .i_byte (r_byte),
        .o_crc  (crc_upd)
    );

    // Use up one attempt, never below zero
    assign left_dec = (r_left != '0) ? r_left - 8'd1 : r_left;

    // Process the held word
    always_comb begin
        n_phase     = r_phase;
        n_left      = r_left;
        n_idx       = r_idx;
        n_crc       = r_crc;
        n_tlo       = r_tlo;
        n_thi       = r_thi;
        n_out_valid = 1'b0;
        n_status    = spcrc_pkg::ST_RETRY;
        n_temp      = '0;
        n_crc_out   = '0;
        unique case (r_cmd)
            spcrc_pkg::CMD_START: begin
                n_left = r_budget;
                n_idx  = '0;
                n_crc  = '0;
                if (r_budget == '0) begin
                    n_phase     = spcrc_pkg::PH_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = spcrc_pkg::ST_FAIL;
                end else begin
                    n_phase = spcrc_pkg::PH_WAIT;
                end
            end
            spcrc_pkg::CMD_PRESENCE: begin
                if (r_phase == spcrc_pkg::PH_WAIT) begin
                    if (r_present) begin
                        n_phase = spcrc_pkg::PH_RECV;
                        n_idx   = '0;
                        n_crc   = '0;
                    end else begin
                        n_left      = left_dec;
                        n_out_valid = 1'b1;
                        if (left_dec == '0) begin
                            n_phase  = spcrc_pkg::PH_IDLE;
                            n_status = spcrc_pkg::ST_FAIL;
                        end else begin
                            n_phase  = spcrc_pkg::PH_WAIT;
                            n_status = spcrc_pkg::ST_RETRY;
                        end
                    end
                end
            end
            spcrc_pkg::CMD_BYTE: begin
                if (r_phase == spcrc_pkg::PH_RECV) begin
                    if (r_idx >= LAST_IDX) begin
                        // Check byte: compare with the running CRC
                        n_idx       = '0;
                        n_out_valid = 1'b1;
                        n_crc_out   = r_crc;
                        if (r_byte == r_crc) begin
                            n_phase  = spcrc_pkg::PH_IDLE;
                            n_status = spcrc_pkg::ST_OK;
                            n_temp   = {r_thi, r_tlo};
                        end else begin
                            n_left = left_dec;
                            if (left_dec == '0) begin
                                n_phase  = spcrc_pkg::PH_IDLE;
                                n_status = spcrc_pkg::ST_FAIL;
                            end else begin
                                n_phase  = spcrc_pkg::PH_WAIT;
                                n_status = spcrc_pkg::ST_RETRY;
                            end
                        end
                    end else begin
                        // Data byte: keep the temperature word, fold into CRC
                        if (r_idx == IDX_W'(0)) begin
                            n_tlo = r_byte;
                        end else if (r_idx == IDX_W'(1)) begin
                            n_thi = r_byte;
                        end
                        n_crc = crc_upd;
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            default: begin
                // Unused command: drop it
            end
        endcase
    end

    // Capture input words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_cmd     <= i_in.command;
            r_budget  <= i_in.attempts;
            r_present <= i_in.presence;
            r_byte    <= i_in.data_byte;
        end
    end

    // Update state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= spcrc_pkg::PH_IDLE;
            r_left      <= '0;
            r_idx       <= '0;
            r_crc       <= '0;
            r_tlo       <= '0;
            r_thi       <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_phase     <= n_phase;
            r_left      <= n_left;
            r_idx       <= n_idx;
            r_crc       <= n_crc;
            r_tlo       <= n_tlo;
            r_thi       <= n_thi;
            r_out_valid <= n_out_valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (adv && n_out_valid) begin
            r_status  <= n_status;
            r_temp    <= n_temp;
            r_crc_out <= n_crc_out;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.temperature = r_temp;
    assign o_out.crc_value   = r_crc_out;

    // Byte index stays inside the frame
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LAST_IDX)
        else $error("byte index beyond frame");

    // An empty output register never blocks the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled with empty output register");

    // Success returns to idle
    a_ok_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && n_out_valid && n_status == spcrc_pkg::ST_OK)
        |=> r_phase == spcrc_pkg::PH_IDLE)
        else $error("phase not idle after success");

    // Failure leaves no attempts
    a_fail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && n_out_valid && n_status == spcrc_pkg::ST_FAIL)
        |=> (r_left == '0 && r_phase == spcrc_pkg::PH_IDLE))
        else $error("attempts left after failure");

endmodule

// ===== rtl/spcrc_crc8.sv =====
// ----------------------------------------------------------------------------
// Scratchpad CRC-8 byte update
// One byte through the reflected CRC-8, eight bit steps unrolled.
// ----------------------------------------------------------------------------
module spcrc_crc8 (
    input  logic [spcrc_pkg::BYTE_W-1:0] i_crc,
    input  logic [spcrc_pkg::BYTE_W-1:0] i_byte,
    output logic [spcrc_pkg::BYTE_W-1:0] o_crc
);

    // Shift one data bit at a time, LSB first
    always_comb begin
        logic [spcrc_pkg::BYTE_W-1:0] crc;
        logic [spcrc_pkg::BYTE_W-1:0] b;
        logic                         fb;
        crc = i_crc;
        b   = i_byte;
        for (int k = 0; k < spcrc_pkg::BYTE_W; k++) begin
            fb  = crc[0] ^ b[0];
            crc = crc >> 1;
            b   = b >> 1;
            if (fb) begin
                crc = crc ^ spcrc_pkg::CRC_POLY;
            end
        end
        o_crc = crc;
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Scratchpad CRC checker testbench
// Drives start, presence and byte words into the checker and compares every
// result word with a cycle-free predictor of the retry and CRC-8 logic. A
// short directed table covers reset, zero and full budgets, ignored words,
// the last failing attempt and an abort mid-frame. One long output stall and
// a drain follow, then random sessions with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int FRAME_LEN   = spcrc_pkg::FRAME_BYTES_DEF;
    localparam int RAND_WORDS  = 625;
    localparam int HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 8;

    typedef struct packed {
        logic [spcrc_pkg::STATUS_W-1:0] status;
        logic [spcrc_pkg::TEMP_W-1:0]   temperature;
        logic [spcrc_pkg::BYTE_W-1:0]   crc_value;
    } t_verdict;

    typedef struct {
        logic [spcrc_pkg::CMD_W-1:0]  cmd;
        logic [spcrc_pkg::BYTE_W-1:0] budget;
        logic                         pres;
        logic [spcrc_pkg::BYTE_W-1:0] data;
        bit                           typed;
        bit                           has;
        t_verdict                     v;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    spcrc_in_if  in_ch ();
    spcrc_out_if out_ch ();

    scratchpad_crc_checker #(
        .FRAME_BYTES (FRAME_LEN)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predictor state, reset values
    logic [1:0]                   ph         = spcrc_pkg::PH_IDLE;
    logic [spcrc_pkg::BYTE_W-1:0] tries_left = '0;
    logic [3:0]                   byte_pos   = '0;
    logic [spcrc_pkg::BYTE_W-1:0] crc_acc    = '0;
    logic [spcrc_pkg::BYTE_W-1:0] temp_lo    = '0;
    logic [spcrc_pkg::BYTE_W-1:0] temp_hi    = '0;

    t_verdict  verdict_q[$];
    t_stim_row dir_rows[$];

    // Typed expectation that travels with the offered word
    bit        cur_typed = 1'b0;
    bit        cur_has   = 1'b0;
    t_verdict  cur_v     = '0;

    bit no_idle  = 1'b0;
    bit hold_req = 1'b0;
    int errors     = 0;
    int stim_words = 0;
    int n_words    = 0;
    int n_results  = 0;
    int n_ok       = 0;
    int n_retry    = 0;
    int n_fail     = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Reflected CRC-8, one byte LSB first
    function automatic logic [spcrc_pkg::BYTE_W-1:0] crc8_byte(
            logic [spcrc_pkg::BYTE_W-1:0] c, logic [spcrc_pkg::BYTE_W-1:0] b);
        logic lsb;
        for (int k = 0; k < 8; k++) begin
            lsb = c[0] ^ b[0];
            c   = c >> 1;
            b   = b >> 1;
            if (lsb) c = c ^ spcrc_pkg::CRC_POLY;
        end
        return c;
    endfunction

    // Use up one attempt: retry while budget remains, else give up
    function automatic t_verdict attempt_lost(logic [spcrc_pkg::BYTE_W-1:0] crc);
        t_verdict v;
        v = '0;
        if (tries_left != 0) tries_left = tries_left - 1'b1;
        if (tries_left == 0) begin
            ph       = spcrc_pkg::PH_IDLE;
            v.status = spcrc_pkg::ST_FAIL;
        end else begin
            ph       = spcrc_pkg::PH_WAIT;
            v.status = spcrc_pkg::ST_RETRY;
        end
        v.crc_value = crc;
        return v;
    endfunction

    // Advance the predictor by one word; returns 1 when a result is due
    function automatic bit predict_verdict(input logic [spcrc_pkg::CMD_W-1:0] cmd,
                                           input logic [spcrc_pkg::BYTE_W-1:0] budget,
                                           input logic pres,
                                           input logic [spcrc_pkg::BYTE_W-1:0] b,
                                           output t_verdict v);
        bit has;
        has = 1'b0;
        v   = '0;
        case (cmd)
            spcrc_pkg::CMD_START: begin
                tries_left = budget;
                byte_pos   = '0;
                crc_acc    = '0;
                if (budget == 0) begin
                    ph       = spcrc_pkg::PH_IDLE;
                    v.status = spcrc_pkg::ST_FAIL;
                    has      = 1'b1;
                end else begin
                    ph = spcrc_pkg::PH_WAIT;
                end
            end
            spcrc_pkg::CMD_PRESENCE: begin
                if (ph == spcrc_pkg::PH_WAIT) begin
                    if (pres) begin
                        ph       = spcrc_pkg::PH_RECV;
                        byte_pos = '0;
                        crc_acc  = '0;
                    end else begin
                        v   = attempt_lost('0);
                        has = 1'b1;
                    end
                end
            end
            spcrc_pkg::CMD_BYTE: begin
                if (ph == spcrc_pkg::PH_RECV) begin
                    if (byte_pos >= FRAME_LEN - 1) begin
                        byte_pos = '0;
                        has      = 1'b1;
                        if (b == crc_acc) begin
                            ph            = spcrc_pkg::PH_IDLE;
                            v.status      = spcrc_pkg::ST_OK;
                            v.temperature = {temp_hi, temp_lo};
                            v.crc_value   = crc_acc;
                        end else begin
                            v = attempt_lost(crc_acc);
                        end
                    end else begin
                        if (byte_pos == 0) temp_lo = b;
                        else if (byte_pos == 1) temp_hi = b;
                        crc_acc  = crc8_byte(crc_acc, b);
                        byte_pos = byte_pos + 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return has;
    endfunction

    function automatic t_stim_row row(logic [spcrc_pkg::CMD_W-1:0] cmd,
                                      logic [spcrc_pkg::BYTE_W-1:0] budget,
                                      logic pres, logic [spcrc_pkg::BYTE_W-1:0] data,
                                      bit typed, bit has,
                                      logic [spcrc_pkg::STATUS_W-1:0] st =
                                          spcrc_pkg::ST_RETRY,
                                      logic [spcrc_pkg::TEMP_W-1:0] temp = '0,
                                      logic [spcrc_pkg::BYTE_W-1:0] crc = '0);
        t_stim_row r;
        r.cmd    = cmd;
        r.budget = budget;
        r.pres   = pres;
        r.data   = data;
        r.typed  = typed;
        r.has    = has;
        r.v      = '{status: st, temperature: temp, crc_value: crc};
        return r;
    endfunction

    // Mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] MISMATCH %s: got %0h expected %0h", $time, what, got, want);
        errors++;
    endtask

    // Offer one word, hold it until taken, then maybe idle
    task automatic send_word(input logic [spcrc_pkg::CMD_W-1:0] cmd,
                             input logic [spcrc_pkg::BYTE_W-1:0] budget,
                             input logic pres, input logic [spcrc_pkg::BYTE_W-1:0] data,
                             input bit typed = 1'b0, input bit has = 1'b0,
                             input t_verdict v = '0);
        int gap;
        in_ch.valid     <= 1'b1;
        in_ch.command   <= cmd;
        in_ch.attempts  <= budget;
        in_ch.presence  <= pres;
        in_ch.data_byte <= data;
        cur_typed       <= typed;
        cur_has         <= has;
        cur_v           <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        stim_words++;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // One random word of any command, often out of place
    task automatic send_noise();
        send_word(spcrc_pkg::CMD_W'($urandom_range(0, 3)),
                  spcrc_pkg::BYTE_W'($urandom_range(0, 255)),
                  1'($urandom), spcrc_pkg::BYTE_W'($urandom_range(0, 255)));
    endtask

    // Start, then presence and, if present, a frame per attempt, for up to six attempts or until success
    task automatic random_session();
        logic [spcrc_pkg::BYTE_W-1:0] budget;
        logic [spcrc_pkg::BYTE_W-1:0] crc;
        logic [spcrc_pkg::BYTE_W-1:0] b;
        logic                         pres;
        int                           pick;
        int                           max_tries;
        pick = $urandom_range(0, 99);
        if (pick < 5) budget = '0;
        else if (pick < 10) budget = 8'hff;
        else if (pick < 20) budget = spcrc_pkg::BYTE_W'($urandom_range(0, 255));
        else budget = spcrc_pkg::BYTE_W'($urandom_range(1, 4));
        no_idle = ($urandom_range(0, 5) == 0);
        send_word(spcrc_pkg::CMD_START, budget, 1'($urandom),
                  spcrc_pkg::BYTE_W'($urandom_range(0, 255)));
        max_tries = (budget < 6) ? budget : 6;
        for (int t = 0; t < max_tries; t++) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            pres = ($urandom_range(0, 3) != 0);
            send_word(spcrc_pkg::CMD_PRESENCE, spcrc_pkg::BYTE_W'($urandom_range(0, 255)),
                      pres, spcrc_pkg::BYTE_W'($urandom_range(0, 255)));
            if (!pres) continue;
            crc = '0;
            for (int i = 0; i < FRAME_LEN - 1; i++) begin
                // drop the session mid-frame now and then; next start aborts it
                if ($urandom_range(0, 99) < 2) return;
                b = spcrc_pkg::BYTE_W'($urandom_range(0, 255));
                send_word(spcrc_pkg::CMD_BYTE, spcrc_pkg::BYTE_W'($urandom_range(0, 255)),
                          1'($urandom), b);
                crc = crc8_byte(crc, b);
            end
            b = crc;
            if ($urandom_range(0, 2) == 0) b = crc ^ spcrc_pkg::BYTE_W'($urandom_range(1, 255));
            send_word(spcrc_pkg::CMD_BYTE, spcrc_pkg::BYTE_W'($urandom_range(0, 255)),
                      1'($urandom), b);
            if (b == crc) break;
        end
    endtask

    // Check results, then predict for the accepted input word
    always @(posedge i_clk) begin
        t_verdict exp_v;
        t_verdict pred_v;
        bit       pred_has;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_results++;
            case (out_ch.status)
                spcrc_pkg::ST_OK:    n_ok++;
                spcrc_pkg::ST_RETRY: n_retry++;
                default:             n_fail++;
            endcase
            if (verdict_q.size() == 0) begin
                report_mismatch("result with nothing pending", out_ch.status, 0);
            end else begin
                exp_v = verdict_q.pop_front();
                if (out_ch.status !== exp_v.status)
                    report_mismatch("status", out_ch.status, exp_v.status);
                if (out_ch.temperature !== exp_v.temperature)
                    report_mismatch("temperature", out_ch.temperature, exp_v.temperature);
                if (out_ch.crc_value !== exp_v.crc_value)
                    report_mismatch("crc_value", out_ch.crc_value, exp_v.crc_value);
            end
        end
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            n_words++;
            pred_has = predict_verdict(in_ch.command, in_ch.attempts, in_ch.presence,
                                       in_ch.data_byte, pred_v);
            if (cur_typed) begin
                pred_has = cur_has;
                pred_v   = cur_v;
            end
            if (pred_has) verdict_q.push_back(pred_v);
        end
    end

    // Output ready: random runs and gaps, plus a long hold-off on request
    initial begin
        int run;
        int gap;
        run = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                run = 0;
            end else if (hold_req) begin
                hold_req     <= 1'b0;
                out_ch.ready <= 1'b0;
                run = HOLD_CYCLES;
            end else if (run > 0) begin
                run--;
            end else if (!out_ch.ready) begin
                out_ch.ready <= 1'b1;
                run = $urandom_range(0, 30);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    out_ch.ready <= 1'b0;
                    run = gap - 1;
                end else begin
                    run = $urandom_range(0, 30);
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        in_ch.valid     = 1'b0;
        in_ch.command   = spcrc_pkg::CMD_START;
        in_ch.attempts  = '0;
        in_ch.presence  = 1'b0;
        in_ch.data_byte = '0;
        i_rst_n         = 1'b0;

        // reset state: zero budget fails at once, stray words are dropped
        dir_rows.push_back(row(spcrc_pkg::CMD_START,    8'h00, 1'b0, 8'h00, 1, 1,
                               spcrc_pkg::ST_FAIL));
        dir_rows.push_back(row(spcrc_pkg::CMD_PRESENCE, 8'hff, 1'b1, 8'hff, 1, 0));
        dir_rows.push_back(row(spcrc_pkg::CMD_BYTE,     8'h00, 1'b0, 8'hff, 1, 0));
        dir_rows.push_back(row(spcrc_pkg::CMD_UNUSED,   8'hff, 1'b1, 8'hff, 1, 0));
        // single attempt with no device gives up
        dir_rows.push_back(row(spcrc_pkg::CMD_START,    8'h01, 1'b1, 8'h00, 1, 0));
        dir_rows.push_back(row(spcrc_pkg::CMD_PRESENCE, 8'h00, 1'b0, 8'h00, 1, 1,
                               spcrc_pkg::ST_FAIL));
        // full budget asks for a retry, then an all-zero frame passes
        dir_rows.push_back(row(spcrc_pkg::CMD_START,    8'hff, 1'b0, 8'hff, 1, 0));
        dir_rows.push_back(row(spcrc_pkg::CMD_PRESENCE, 8'h00, 1'b0, 8'h00, 1, 1,
                               spcrc_pkg::ST_RETRY));
        dir_rows.push_back(row(spcrc_pkg::CMD_PRESENCE, 8'h00, 1'b1, 8'h00, 1, 0));
        for (int i = 0; i < FRAME_LEN - 1; i++)
            dir_rows.push_back(row(spcrc_pkg::CMD_BYTE, 8'hff, 1'b1, 8'h00, 1, 0));
        dir_rows.push_back(row(spcrc_pkg::CMD_BYTE,     8'h00, 1'b0, 8'h00, 1, 1,
                               spcrc_pkg::ST_OK));
        // abort mid-frame with a new start; its budget of one then runs out
        dir_rows.push_back(row(spcrc_pkg::CMD_START,    8'h02, 1'b1, 8'h00, 1, 0));
        dir_rows.push_back(row(spcrc_pkg::CMD_PRESENCE, 8'h00, 1'b1, 8'h00, 1, 0));
        dir_rows.push_back(row(spcrc_pkg::CMD_BYTE,     8'h00, 1'b0, 8'hff, 0, 0));
        dir_rows.push_back(row(spcrc_pkg::CMD_BYTE,     8'h00, 1'b0, 8'h80, 0, 0));
        dir_rows.push_back(row(spcrc_pkg::CMD_START,    8'h01, 1'b0, 8'h00, 1, 0));
        dir_rows.push_back(row(spcrc_pkg::CMD_BYTE,     8'h00, 1'b1, 8'h12, 1, 0));
        dir_rows.push_back(row(spcrc_pkg::CMD_PRESENCE, 8'hff, 1'b0, 8'hff, 1, 1,
                               spcrc_pkg::ST_FAIL));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].cmd, dir_rows[i].budget, dir_rows[i].pres,
                      dir_rows[i].data, dir_rows[i].typed, dir_rows[i].has, dir_rows[i].v);

        // long output stall while retries keep coming back to back
        no_idle = 1'b1;
        hold_req <= 1'b1;
        send_word(spcrc_pkg::CMD_START, 8'd200, 1'b1, 8'h5a);
        repeat (12) send_word(spcrc_pkg::CMD_PRESENCE, 8'h00, 1'b0, 8'ha5);
        in_ch.valid <= 1'b0;

        // drain before the random sessions; let the last prediction land first
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        no_idle = 1'b0;

        while (stim_words < dir_rows.size() + 13 + RAND_WORDS)
            random_session();
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d input words and %0d results (%0d success, %0d retry, %0d fail),",
                 n_words, n_results, n_ok, n_retry, n_fail);
        $display("with random gaps on both channels, one %0d-cycle output stall and a drain.",
                 HOLD_CYCLES);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #500000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== scratchpad_crc_checker.f =====
rtl/spcrc_pkg.sv
rtl/spcrc_if.sv
rtl/spcrc_crc8.sv
rtl/scratchpad_crc_checker.sv
dv/tb_top.sv
